FILE: hw/rtl/ketul_pkg.sv
`timescale 1ns / 1ps
package ketul_pkg;

  // default sizes of the table
  localparam int unsigned TABLE_DEPTH_DEF  = 16;
  localparam int unsigned ID_BITS_DEF      = 64;
  localparam int unsigned PAYLOAD_BITS_DEF = 64;

  // fixed field widths on the stream ports
  localparam int unsigned FIELD_BITS    = 64;
  localparam int unsigned STATUS_BITS   = 2;
  localparam int unsigned SLOT_BITS     = 4;
  localparam int unsigned CFG_BITS      = 5;
  localparam int unsigned IN_DATA_BITS  = 3 * FIELD_BITS;
  localparam int unsigned OUT_USED_BITS = STATUS_BITS + FIELD_BITS + SLOT_BITS;
  localparam int unsigned OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  // reset value of the entries-in-use register
  localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_READ  = 1'b1
  } func_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic start;     // latch the item, clear search state
    logic rd_issue;  // read the slot at the walk index
    logic cmp;       // evaluate the slot just read, advance
    logic commit;    // update the table and load the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic span_zero;  // no slot is searched
    logic last;       // walk index is the last slot in use
    logic out_free;   // result register can take a result
  } sts_t;

endpackage

FILE: hw/rtl/ketul_ram.sv
`timescale 1ns / 1ps
module ketul_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ketul_ctrl.sv
`timescale 1ns / 1ps
module ketul_ctrl
  import ketul_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_CMP    = 4'b0100,
    S_COMMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.span_zero ? S_COMMIT : S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = sts_i.last ? S_COMMIT : S_READ;
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a result is only loaded when the result register has room
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> sts_i.out_free)
    else $error("commit while result register busy");

  // an accepted transaction always starts a walk or goes straight to commit
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_READ || state_q == S_COMMIT))
    else $error("bad state after accept");

endmodule

FILE: hw/rtl/ketul_dp.sv
`timescale 1ns / 1ps
module ketul_dp
  import ketul_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int unsigned ID_BITS      = ID_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_BITS-1:0]    cfg_wdata_i,
  input  logic                   in_func_i,
  input  logic [FIELD_BITS-1:0]  in_client_id_i,
  input  logic [FIELD_BITS-1:0]  in_server_id_i,
  input  logic [FIELD_BITS-1:0]  in_payload_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [STATUS_BITS-1:0] out_status_o,
  output logic [FIELD_BITS-1:0]  out_payload_o,
  output logic [SLOT_BITS-1:0]   out_slot_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned SPAN_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW     = (SPAN_W > CFG_BITS) ? SPAN_W : CFG_BITS;
  localparam int unsigned ROW_W  = 2 * ID_BITS + PAYLOAD_BITS;

  logic [CFG_BITS-1:0]     euse_q;
  func_e                   func_q;
  logic [ID_BITS-1:0]      cid_q, sid_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    hit_q, emp_q;
  logic [IDX_W-1:0]        hit_idx_q, emp_idx_q;
  logic [PAYLOAD_BITS-1:0] hit_pay_q;
  logic [TABLE_DEPTH-1:0]  valid_q;
  logic                    rvalid_q;
  logic                    out_valid_q;
  logic [STATUS_BITS-1:0]  out_status_q;
  logic [FIELD_BITS-1:0]   out_payload_q;
  logic [SLOT_BITS-1:0]    out_slot_q;

  logic [CW-1:0]           span;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_addr;
  logic [ROW_W-1:0]        ram_wdata, ram_rdata;
  logic [ID_BITS-1:0]      row_cid, row_sid;
  logic [PAYLOAD_BITS-1:0] row_pay;
  logic                    row_match, row_empty;
  logic [IDX_W-1:0]        sel_idx;
  logic                    wr_ok, rd_ok;

  // entries-in-use register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      euse_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      euse_q <= cfg_wdata_i;
    end
  end

  // searched span, saturated at table depth
  assign span = (CW'(euse_q) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(euse_q);
  assign sts_o.span_zero = (span == '0);
  assign sts_o.last      = ((CW'(idx_q) + CW'(1)) == span);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q <= func_e'(in_func_i);
      cid_q  <= in_client_id_i[ID_BITS-1:0];
      sid_q  <= in_server_id_i[ID_BITS-1:0];
      pay_q  <= in_payload_i[PAYLOAD_BITS-1:0];
    end
  end

  // slot just read, an entry never written reads as zero
  assign row_cid   = rvalid_q ? ram_rdata[ID_BITS-1:0] : '0;
  assign row_sid   = rvalid_q ? ram_rdata[2*ID_BITS-1:ID_BITS] : '0;
  assign row_pay   = rvalid_q ? ram_rdata[ROW_W-1:2*ID_BITS] : '0;
  assign row_match = (row_cid == cid_q) && (row_sid == sid_q);
  assign row_empty = (row_cid == '0) && (row_sid == '0) && (row_pay == '0);

  // walk index and first match / first empty slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      hit_q <= 1'b0;
      emp_q <= 1'b0;
    end else if (cmd_i.start) begin
      idx_q <= '0;
      hit_q <= 1'b0;
      emp_q <= 1'b0;
    end else if (cmd_i.cmp) begin
      idx_q <= idx_q + IDX_W'(1);
      if (!hit_q && row_match) begin
        hit_q <= 1'b1;
      end
      if (!emp_q && row_empty) begin
        emp_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      if (!hit_q && row_match) begin
        hit_idx_q <= idx_q;
        hit_pay_q <= row_pay;
      end
      if (!emp_q && row_empty) begin
        emp_idx_q <= idx_q;
      end
    end
  end

  // table update
  assign sel_idx   = hit_q ? hit_idx_q : emp_idx_q;
  assign wr_ok     = (func_q == FUNC_WRITE) && (hit_q || emp_q);
  assign rd_ok     = (func_q == FUNC_READ) && hit_q;
  assign ram_we    = cmd_i.commit && wr_ok;
  assign ram_addr  = cmd_i.commit ? sel_idx : idx_q;
  assign ram_wdata = {pay_q, sid_q, cid_q};

  ketul_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.rd_issue),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // per-slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_q[ram_addr] <= 1'b1;
      end
      if (cmd_i.rd_issue) begin
        rvalid_q <= valid_q[idx_q];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (wr_ok || rd_ok) begin
        out_status_q <= ST_OK;
        out_slot_q   <= SLOT_BITS'(sel_idx);
      end else begin
        out_status_q <= (func_q == FUNC_WRITE) ? ST_FULL : ST_MISSING;
        out_slot_q   <= '0;
      end
      out_payload_q <= rd_ok ? FIELD_BITS'(hit_pay_q) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = out_status_q;
  assign out_payload_o = out_payload_q;
  assign out_slot_o    = out_slot_q;

  // read and write of the table never share a cycle
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && cmd_i.rd_issue))
    else $error("table read and write in one cycle");

  // a written slot is marked valid
  a_valid_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(ram_addr)])
    else $error("written slot not marked valid");

  // every commit presents a result
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("commit without result");

endmodule

FILE: hw/rtl/keyed_entry_table_upsert_lookup.sv
`timescale 1ns / 1ps
// Keyed entry table: upsert and lookup of (client id, server id) -> payload.
// Input channel s_axis: tuser carries the operation (0 write/update, 1 read),
// tdata carries client id, server id and payload. Output channel m_axis:
// tdata carries status (0 ok, 1 full, 2 not found), payload and slot index.
// cfg_we_i/cfg_wdata_i write the number of slots searched (reset 16,
// saturated at the table depth); write it only while the block is idle.
// One transaction is handled at a time. The table is walked slot by slot
// (read issue, then compare) through a single-port RAM, keeping the first
// matching and the first empty slot, then a commit step writes the table
// and loads the result register. A new transaction is taken only once the
// previous one has committed.
// The result register lets a new transaction be accepted while the last
// result waits; if the receiver stalls, the next commit waits for it.
// Reset clears per-slot valid bits at once, so every slot reads as zero;
// no clearing pass is needed.
module keyed_entry_table_upsert_lookup
  import ketul_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int unsigned ID_BITS      = ID_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_BITS-1:0]      cfg_wdata_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // client_id [63:0], server_id [127:64], payload_in [191:128]
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // func [0]
  input  logic [0:0]               s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // status [1:0], payload_out [65:2], slot_index [69:66], zero [71:70]
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

  cmd_t                   cmd;
  sts_t                   sts;
  logic [STATUS_BITS-1:0] out_status;
  logic [FIELD_BITS-1:0]  out_payload;
  logic [SLOT_BITS-1:0]   out_slot;

  ketul_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ketul_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .ID_BITS      (ID_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_func_i      (s_axis_tuser[0]),
    .in_client_id_i (s_axis_tdata[FIELD_BITS-1:0]),
    .in_server_id_i (s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]),
    .in_payload_i   (s_axis_tdata[3*FIELD_BITS-1:2*FIELD_BITS]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_status_o   (out_status),
    .out_payload_o  (out_payload),
    .out_slot_o     (out_slot)
  );

  // result packing
  assign m_axis_tdata = {{(OUT_DATA_BITS - OUT_USED_BITS){1'b0}},
                         out_slot, out_payload, out_status};

endmodule

FILE: tb/sv/keyed_entry_table_checker.sv
`timescale 1ns / 1ps
module keyed_entry_table_checker
  import ketul_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_BITS-1:0]      cfg_wdata_i,
  input  logic                     op_valid_i,
  input  logic                     op_ready_i,
  // client_id [63:0], server_id [127:64], payload_in [191:128]
  input  logic [IN_DATA_BITS-1:0]  op_data_i,
  // func [0]
  input  logic [0:0]               op_user_i,
  input  logic                     res_valid_i,
  input  logic                     res_ready_i,
  // status [1:0], payload_out [65:2], slot_index [69:66]
  input  logic [OUT_DATA_BITS-1:0] res_data_i,
  output int                       mismatches_o,
  output int                       pending_o
);

  localparam int DEPTH = TABLE_DEPTH_DEF;

  // result bit positions on the output bus
  localparam int PAY_LO  = STATUS_BITS;
  localparam int SLOT_LO = STATUS_BITS + FIELD_BITS;

  typedef struct packed {
    status_e                status;
    logic [FIELD_BITS-1:0]  payload;
    logic [SLOT_BITS-1:0]   slot;
  } table_result_t;

  // shadow copy of the table and the search span
  logic [FIELD_BITS-1:0] client_tbl  [DEPTH];
  logic [FIELD_BITS-1:0] server_tbl  [DEPTH];
  logic [FIELD_BITS-1:0] payload_tbl [DEPTH];
  logic [CFG_BITS-1:0]   slots_in_use;

  table_result_t expected_results [$];
  table_result_t oldest;

  // upsert or lookup on the shadow table, returns the result it should give
  function automatic table_result_t apply_table_op(func_e op, logic [FIELD_BITS-1:0] cid,
                                                   logic [FIELD_BITS-1:0] sid,
                                                   logic [FIELD_BITS-1:0] pay);
    table_result_t res;
    int            span;
    int            hit;
    span = (slots_in_use > DEPTH) ? DEPTH : int'(slots_in_use);
    hit = -1;
    res = '0;
    res.status = ST_OK;
    // lowest slot in use with both ids equal
    for (int i = 0; i < span; i++) begin
      if (hit < 0 && client_tbl[i] == cid && server_tbl[i] == sid) hit = i;
    end
    if (op == FUNC_WRITE) begin
      // no key match: take the lowest all-zero slot
      for (int i = 0; i < span; i++) begin
        if (hit < 0 && client_tbl[i] == '0 && server_tbl[i] == '0 && payload_tbl[i] == '0)
          hit = i;
      end
      if (hit >= 0) begin
        client_tbl[hit]  = cid;
        server_tbl[hit]  = sid;
        payload_tbl[hit] = pay;
        res.slot = hit[SLOT_BITS-1:0];
      end else begin
        res.status = ST_FULL;
      end
    end else begin
      if (hit >= 0) begin
        res.payload = payload_tbl[hit];
        res.slot    = hit[SLOT_BITS-1:0];
      end else begin
        res.status = ST_MISSING;
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [FIELD_BITS-1:0] want,
                             input logic [FIELD_BITS-1:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, seen);
      mismatches_o++;
    end
  endtask

  // track both channels, result side first so an item never meets its own result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        client_tbl[i]  = '0;
        server_tbl[i]  = '0;
        payload_tbl[i] = '0;
      end
      slots_in_use = CFG_RESET;
      expected_results.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing pending: data 0x%0h", res_data_i);
          mismatches_o++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("status", FIELD_BITS'(oldest.status),
                      FIELD_BITS'(res_data_i[STATUS_BITS-1:0]));
          check_field("payload_out", oldest.payload, res_data_i[PAY_LO +: FIELD_BITS]);
          check_field("slot_index", FIELD_BITS'(oldest.slot),
                      FIELD_BITS'(res_data_i[SLOT_LO +: SLOT_BITS]));
        end
      end
      if (cfg_we_i) slots_in_use = cfg_wdata_i;
      if (op_valid_i && op_ready_i) begin
        expected_results.push_back(apply_table_op(func_e'(op_user_i[0]),
                                                  op_data_i[0 +: FIELD_BITS],
                                                  op_data_i[FIELD_BITS +: FIELD_BITS],
                                                  op_data_i[2*FIELD_BITS +: FIELD_BITS]));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

FILE: tb/sv/keyed_entry_table_upsert_lookup_tb.sv
`timescale 1ns / 1ps
module keyed_entry_table_upsert_lookup_tb;
  import ketul_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_AFTER   = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int POOL_SIZE    = 12;
  localparam int PHASES       = 10;

  typedef struct packed {
    logic [FIELD_BITS-1:0] client;
    logic [FIELD_BITS-1:0] server;
  } id_pair_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [CFG_BITS-1:0]      cfg_wdata;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  // client_id [63:0], server_id [127:64], payload_in [191:128]
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;
  // func [0]
  logic [0:0]               s_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  // status [1:0], payload_out [65:2], slot_index [69:66], zero [71:70]
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  int mismatches;
  int pending;
  int results_seen = 0;
  bit send_calm;
  bit recv_calm;

  id_pair_t            key_pool    [POOL_SIZE];
  logic [CFG_BITS-1:0] phase_span  [PHASES] = '{5'd0, 5'd1, 5'd3, 5'd8, 5'd16,
                                                5'd31, 5'd2, 5'd12, 5'd17, 5'd16};
  int                  phase_items [PHASES] = '{30, 80, 120, 150, 200,
                                                200, 100, 150, 150, 250};

  keyed_entry_table_upsert_lookup uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  keyed_entry_table_checker table_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .op_valid_i   (s_axis_tvalid),
    .op_ready_i   (s_axis_tready),
    .op_data_i    (s_axis_tdata),
    .op_user_i    (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // run limit
  initial begin
    #10_200_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [FIELD_BITS-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // count result transactions for the long receiver hold-off
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
  end

  // result receiver: random stalls, one long hold-off
  initial begin : receiver
    int stall;
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= HOLD_AFTER) begin
        m_axis_tready <= 1'b0;
        held = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        stall = pick_gap(recv_calm);
        if (stall == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end
      end
    end
  end

  // offer one operation and hold it until the block takes it
  task automatic send_op(func_e op, id_pair_t key, logic [FIELD_BITS-1:0] pay);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {pay, key.server, key.client};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // mostly known keys so updates and hits happen, some fresh keys to fill the table
  task automatic random_op();
    int                    pick;
    id_pair_t              key;
    logic [FIELD_BITS-1:0] pay;
    func_e                 op;
    if ($urandom_range(0, 99) < 45) op = FUNC_READ;
    else op = FUNC_WRITE;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      key.client = rand64();
      key.server = rand64();
      if (pick == 0) key.client = '0;
      if (pick == 1) key.server = '0;
    end else begin
      key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    pick = $urandom_range(0, 99);
    if (pick < 15) pay = '0;
    else if (pick < 20) pay = '1;
    else pay = rand64();
    send_op(op, key, pay);
  endtask

  // stop offering until every result is back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_span(logic [CFG_BITS-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // stimulus and verdict
  initial begin : stimulus
    id_pair_t mixed;
    logic [FIELD_BITS-1:0] zero_key_pay;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    send_calm     = 1'b0;
    recv_calm     = 1'b0;

    // key pool: zero ids, all ones, shared client, shared server, one half zero
    key_pool[0] = '{client: '0, server: '0};
    key_pool[1] = '{client: '1, server: '1};
    key_pool[2] = '{client: rand64(), server: rand64()};
    key_pool[3] = '{client: key_pool[2].client, server: rand64()};
    key_pool[4] = '{client: rand64(), server: key_pool[2].server};
    key_pool[5] = '{client: '0, server: rand64()};
    key_pool[6] = '{client: rand64(), server: '0};
    for (int i = 7; i < POOL_SIZE; i++) key_pool[i] = '{client: rand64(), server: rand64()};
    mixed = '{client: key_pool[4].client, server: key_pool[3].server};
    zero_key_pay = rand64();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: zero ids on an empty table, miss, extremes, partial key matches
    send_op(FUNC_READ,  key_pool[0], rand64());
    send_op(FUNC_READ,  '{client: 64'd1, server: 64'd1}, '0);
    send_op(FUNC_WRITE, key_pool[1], '1);
    send_op(FUNC_READ,  key_pool[1], '0);
    send_op(FUNC_WRITE, key_pool[0], zero_key_pay);
    send_op(FUNC_WRITE, key_pool[2], rand64());
    send_op(FUNC_WRITE, key_pool[3], rand64());
    send_op(FUNC_WRITE, key_pool[4], rand64());
    send_op(FUNC_READ,  key_pool[3], '0);
    send_op(FUNC_READ,  key_pool[2], '0);
    send_op(FUNC_READ,  key_pool[4], '0);
    send_op(FUNC_READ,  mixed, '0);
    // update in place, zero payload stored
    send_op(FUNC_WRITE, key_pool[2], '0);
    send_op(FUNC_READ,  key_pool[2], '1);
    send_op(FUNC_READ,  key_pool[0], '0);
    // zero-id entry cleared back to an empty slot, then reused
    send_op(FUNC_WRITE, key_pool[0], '0);
    send_op(FUNC_WRITE, key_pool[5], rand64());
    send_op(FUNC_WRITE, key_pool[6], rand64());
    send_op(FUNC_WRITE, key_pool[0], '0);
    send_op(FUNC_READ,  key_pool[0], '0);
    send_op(FUNC_READ,  key_pool[1], '1);
    drain();

    // random phases over several search spans, zero and saturating among them
    for (int p = 0; p < PHASES; p++) begin
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      write_span(phase_span[p]);
      repeat (phase_items[p]) random_op();
      drain();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
